/* hw/rtl/model_residual_fault_detector_macros.svh */
// Assertion macros shared by the fault detector RTL.
`ifndef MODEL_RESIDUAL_FAULT_DETECTOR_MACROS_SVH
`define MODEL_RESIDUAL_FAULT_DETECTOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MRFD_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define MRFD_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/mrfd_pkg.sv */
// Types, codes and helper functions of the model residual fault detector.
package mrfd_pkg;

   localparam int VAL_W      = 32;
   localparam int COEF_W     = 30;
   localparam int RES_W      = 31;
   localparam int ACT_W      = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACT_W-1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ENABLE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd2;

   localparam logic [1:0] REG_TIME_STEP = 2'd0;
   localparam logic [1:0] REG_DECAY     = 2'd1;
   localparam logic [1:0] REG_GAIN      = 2'd2;
   localparam logic [1:0] REG_THRESHOLD = 2'd3;

   localparam logic [COEF_W-1:0] TIME_STEP_RESET = 30'd12240657;
   localparam logic [COEF_W-1:0] DECAY_RESET     = 30'd1051837491;
   localparam logic [COEF_W-1:0] GAIN_RESET      = 30'd55083;
   localparam logic [RES_W-1:0]  THRESHOLD_RESET = 31'd22938;

   // Half of one output LSB in Q.30 product scaling, for round half up.
   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_2000_0000;

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic signed [VAL_W-1:0] meas_position;
      logic signed [VAL_W-1:0] meas_speed;
      logic signed [VAL_W-1:0] meas_accel;
      logic signed [VAL_W-1:0] accel_command;
      logic signed [VAL_W-1:0] accel_error;
      logic signed [VAL_W-1:0] drive_output;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] predicted_position;
      logic [RES_W-1:0]        residual;
      logic [RES_W-1:0]        window_peak;
      logic                    fault;
   } rsp_type;

   // Saturate a 34-bit two's complement sum to the signed 32-bit range.
   function automatic logic signed [VAL_W-1:0] sat32(input logic [VAL_W+1:0] v);
      logic signed [VAL_W-1:0] r;
      if ((v[VAL_W+1:VAL_W-1] == 3'b000) || (v[VAL_W+1:VAL_W-1] == 3'b111)) begin
         r = v[VAL_W-1:0];
      end else if (v[VAL_W+1]) begin
         r = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(VAL_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/mrfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mrfd_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 150
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/model_residual_fault_detector.sv */
// Top level of the model residual fault detector: sequencer, shared multiplier, window scan.
//
// Single-axis fault detector. An enable transaction loads a five-entry linear
// model from the measured telemetry and starts tracking; a disable transaction
// stops it. While tracking, each sample transaction steps the model once, stores
// the absolute position residual in a circular window of WINDOW_LENGTH entries,
// scans the whole window for its largest value and returns the prediction, the
// residual, the window peak and a fault flag (peak above fault_threshold). After
// WINDOW_LENGTH samples the write index wraps and the model reloads from that
// sample's measurements. Enable, disable and samples while idle return nothing.
// A tracked sample steps through the states MUL0, MUL1, MUL2 and MUL3, which use
// the one shared 31x32 multiplier, then ACC, ROUND and RES for the rest of the
// model arithmetic and the residual, then SCAN, which reads the whole window from
// the RAM read port, then FIN, which loads the output register and waits as long
// as an older result is still stalled; the next transaction is accepted once the
// block is back in idle. After reset the block clears every entry of the window
// RAM, one entry per cycle, before it takes a sample; configuration writes are
// taken during that pass.
module model_residual_fault_detector #(
   parameter int WINDOW_LENGTH = 150
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mrfd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mrfd_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mrfd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mrfd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mrfd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int AW = $clog2(WINDOW_LENGTH);
   localparam int CW = $clog2(WINDOW_LENGTH + 1);
   localparam logic [AW-1:0] IDX_LAST = AW'(WINDOW_LENGTH - 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(WINDOW_LENGTH - 1);
   localparam logic [CW-1:0] CNT_N    = CW'(WINDOW_LENGTH);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_MUL0  = 4'd2;
   localparam logic [3:0] ST_MUL1  = 4'd3;
   localparam logic [3:0] ST_MUL2  = 4'd4;
   localparam logic [3:0] ST_MUL3  = 4'd5;
   localparam logic [3:0] ST_ACC   = 4'd6;
   localparam logic [3:0] ST_ROUND = 4'd7;
   localparam logic [3:0] ST_RES   = 4'd8;
   localparam logic [3:0] ST_SCAN  = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;

   // Configuration registers.
   logic [mrfd_pkg::COEF_W-1:0] dt_ff, dt_in;
   logic [mrfd_pkg::COEF_W-1:0] decay_ff, decay_in;
   logic [mrfd_pkg::COEF_W-1:0] gain_ff, gain_in;
   logic [mrfd_pkg::RES_W-1:0]  thr_ff, thr_in;
   logic                        csr_we;

   // Control state.
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic          trk_ff, trk_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Datapath.
   logic signed [mrfd_pkg::VAL_W-1:0] mdl_ff [5];
   logic signed [mrfd_pkg::VAL_W-1:0] mdl_in [5];
   mrfd_pkg::req_type                 req_ff, req_in;
   mrfd_pkg::rsp_type                 rsp_ff, rsp_in;
   logic signed [62:0]                prod_ff, prod_in;
   logic [63:0]                       sum_ff, sum_in;
   logic [mrfd_pkg::VAL_W:0]          diff_ff, diff_in;
   logic [mrfd_pkg::RES_W-1:0]        res_ff, res_in;
   logic [mrfd_pkg::RES_W-1:0]        peak_ff, peak_in;

   // Shared multiplier.
   logic [mrfd_pkg::COEF_W-1:0]       mul_a;
   logic signed [mrfd_pkg::VAL_W-1:0] mul_b;
   logic signed [62:0]                mul_p;

   // Window RAM ports.
   logic                       ram_we;
   logic [AW-1:0]              ram_waddr;
   logic [mrfd_pkg::RES_W-1:0] ram_wdata;
   logic                       ram_re;
   logic [mrfd_pkg::RES_W-1:0] ram_rdata;

   logic                       req_accept;
   logic [mrfd_pkg::VAL_W:0]   mag;
   logic                       peak_covers_res;

   mrfd_ram #(
      .WIDTH(mrfd_pkg::RES_W),
      .DEPTH(WINDOW_LENGTH)
   ) u_window (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(scan_ff[AW-1:0]),
      .rd_data(ram_rdata)
   );

   // Configuration port.
   assign pready = 1'b1;
   assign csr_we = psel & penable & pwrite & pready;

   always_comb begin
      dt_in    = dt_ff;
      decay_in = decay_ff;
      gain_in  = gain_ff;
      thr_in   = thr_ff;
      if (csr_we) begin
         case (paddr[3:2])
            mrfd_pkg::REG_TIME_STEP: dt_in    = pwdata[mrfd_pkg::COEF_W-1:0];
            mrfd_pkg::REG_DECAY:     decay_in = pwdata[mrfd_pkg::COEF_W-1:0];
            mrfd_pkg::REG_GAIN:      gain_in  = pwdata[mrfd_pkg::COEF_W-1:0];
            mrfd_pkg::REG_THRESHOLD: thr_in   = pwdata[mrfd_pkg::RES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         mrfd_pkg::REG_TIME_STEP: prdata = {2'b00, dt_ff};
         mrfd_pkg::REG_DECAY:     prdata = {2'b00, decay_ff};
         mrfd_pkg::REG_GAIN:      prdata = {2'b00, gain_ff};
         mrfd_pkg::REG_THRESHOLD: prdata = {1'b0, thr_ff};
         default:                 prdata = '0;
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_MUL0: begin
            mul_a = dt_ff;
            mul_b = mdl_ff[1];
         end
         ST_MUL1: begin
            mul_a = dt_ff;
            mul_b = mdl_ff[2];
         end
         ST_MUL2: begin
            mul_a = decay_ff;
            mul_b = mdl_ff[3];
         end
         default: begin
            mul_a = gain_ff;
            mul_b = req_ff.drive_output;
         end
      endcase
      mul_p = $signed({1'b0, mul_a}) * mul_b;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;

   // Magnitude of the position difference, 33 bits so that the most negative value fits.
   assign mag = diff_ff[mrfd_pkg::VAL_W] ? (~diff_ff + 33'd1) : diff_ff;

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      wr_idx_in    = wr_idx_ff;
      trk_in       = trk_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      mdl_in       = mdl_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      diff_in      = diff_ff;
      res_in       = res_ff;
      peak_in      = peak_ff;
      ram_we       = 1'b0;
      ram_waddr    = scan_ff[AW-1:0];
      ram_wdata    = '0;
      ram_re       = 1'b0;
      rd_vld_in    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (scan_ff == CNT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.action)
                  mrfd_pkg::ACT_ENABLE: begin
                     if (!trk_ff) begin
                        trk_in    = 1'b1;
                        wr_idx_in = '0;
                        mdl_in[0] = req_data.meas_position;
                        mdl_in[1] = req_data.meas_speed;
                        mdl_in[2] = req_data.meas_accel;
                        mdl_in[3] = req_data.accel_command;
                        mdl_in[4] = req_data.accel_error;
                     end
                  end
                  mrfd_pkg::ACT_DISABLE: begin
                     trk_in = 1'b0;
                  end
                  mrfd_pkg::ACT_SAMPLE: begin
                     if (trk_ff) begin
                        req_in    = req_data;
                        mdl_in[4] = req_data.accel_error;
                        state_in  = ST_MUL0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL0: begin
            prod_in  = mul_p;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            sum_in   = {prod_ff[62], prod_ff} + mrfd_pkg::ROUND_HALF;
            prod_in  = mul_p;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mdl_in[0] = mrfd_pkg::sat32({{2{mdl_ff[0][31]}}, mdl_ff[0]} + sum_ff[63:30]);
            sum_in    = {prod_ff[62], prod_ff} + mrfd_pkg::ROUND_HALF;
            prod_in   = mul_p;
            state_in  = ST_MUL3;
         end
         ST_MUL3: begin
            mdl_in[1] = mrfd_pkg::sat32({{2{mdl_ff[1][31]}}, mdl_ff[1]} + sum_ff[63:30]);
            sum_in    = {prod_ff[62], prod_ff} + mrfd_pkg::ROUND_HALF;
            prod_in   = mul_p;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            // The drive term joins the decay term before the single rounding.
            sum_in    = sum_ff + {prod_ff[62], prod_ff};
            mdl_in[2] = mrfd_pkg::sat32({{2{mdl_ff[3][31]}}, mdl_ff[3]}
                                        + {{2{mdl_ff[4][31]}}, mdl_ff[4]});
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            mdl_in[3] = mrfd_pkg::sat32(sum_ff[63:30]);
            diff_in   = {req_ff.meas_position[31], req_ff.meas_position}
                        - {mdl_ff[0][31], mdl_ff[0]};
            state_in  = ST_RES;
         end
         ST_RES: begin
            res_in    = (mag[32:31] != 2'b00) ? '1 : mag[mrfd_pkg::RES_W-1:0];
            ram_we    = 1'b1;
            ram_waddr = wr_idx_ff;
            ram_wdata = res_in;
            scan_in   = '0;
            peak_in   = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff != CNT_N) begin
               ram_re    = 1'b1;
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CW'(1);
            end
            if (rd_vld_ff && (ram_rdata > peak_ff)) begin
               peak_in = ram_rdata;
            end
            if ((scan_ff == CNT_N) && !rd_vld_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Wait here only while an older transaction still holds the output register.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_in.predicted_position = mdl_ff[0];
               rsp_in.residual           = res_ff;
               rsp_in.window_peak        = peak_ff;
               rsp_in.fault              = (peak_ff > thr_ff);
               if (wr_idx_ff == IDX_LAST) begin
                  wr_idx_in = '0;
                  mdl_in[0] = req_ff.meas_position;
                  mdl_in[1] = req_ff.meas_speed;
                  mdl_in[2] = req_ff.meas_accel;
                  mdl_in[3] = req_ff.accel_command;
                  mdl_in[4] = req_ff.accel_error;
               end else begin
                  wr_idx_in = wr_idx_ff + AW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff        <= mrfd_pkg::TIME_STEP_RESET;
         decay_ff     <= mrfd_pkg::DECAY_RESET;
         gain_ff      <= mrfd_pkg::GAIN_RESET;
         thr_ff       <= mrfd_pkg::THRESHOLD_RESET;
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         wr_idx_ff    <= '0;
         trk_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dt_ff        <= dt_in;
         decay_ff     <= decay_in;
         gain_ff      <= gain_in;
         thr_ff       <= thr_in;
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         wr_idx_ff    <= wr_idx_in;
         trk_ff       <= trk_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mdl_ff  <= mdl_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
      res_ff  <= res_in;
      peak_ff <= peak_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign peak_covers_res = (rsp_ff.window_peak >= rsp_ff.residual);

`include "model_residual_fault_detector_macros.svh"

   `MRFD_CHECK(a_idx_in_window, wr_idx_ff <= IDX_LAST, "write index beyond window")
   `MRFD_IMPLIES(a_step_needs_tracking, state_ff == ST_MUL0, trk_ff, "model step while idle")
   `MRFD_IMPLIES(a_rsp_from_fin, $rose(rsp_valid_ff), $past(state_ff) == ST_FIN, "result not from final step")
   `MRFD_IMPLIES(a_peak_covers_res, rsp_valid_ff, peak_covers_res, "window peak below residual")

endmodule
